### hw/rtl/free_page_stack_allocator_assert.svh
// Assertion macros for the free page stack allocator.
// Each macro takes a label, a property expression and a message.
`ifndef FREE_PAGE_STACK_ALLOCATOR_ASSERT_SVH
`define FREE_PAGE_STACK_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Check on every rising edge outside reset.
`define FPSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every rising edge, reset included.
`define FPSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define FPSA_ASSERT(lbl, prop, msg)
`define FPSA_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### hw/rtl/fpsa_pkg.sv
package fpsa_pkg;

  localparam int MAX_FREE_PAGES = 4096;
  localparam int PAGE_SHIFT     = 12;

  localparam int ADDR_W  = 32;
  localparam int FRAME_W = ADDR_W - PAGE_SHIFT;
  localparam int CNT_W   = $clog2(MAX_FREE_PAGES + 1);
  localparam int IDX_W   = $clog2(MAX_FREE_PAGES);
  localparam int STAT_W  = 3;

  typedef logic [STAT_W-1:0] status_t;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_EMPTY     = 3'd1;
  localparam status_t ST_UNALIGNED = 3'd2;
  localparam status_t ST_TOO_LOW   = 3'd3;
  localparam status_t ST_TOO_HIGH  = 3'd4;
  localparam status_t ST_FULL      = 3'd5;

  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Requests from the control logic to the frame stack.
  typedef struct packed {
    logic push;
    logic pop;
  } stack_req_t;

  // Fill state of the frame stack.
  typedef struct packed {
    logic empty;
    logic full;
  } stack_stat_t;

endpackage

### hw/rtl/fpsa_frame_stack.sv
module fpsa_frame_stack
  import fpsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  stack_req_t         req,
  input  logic [FRAME_W-1:0] push_frame,
  output stack_stat_t        stat,
  output logic [FRAME_W-1:0] pop_frame
);

  logic [FRAME_W-1:0] frame_mem [MAX_FREE_PAGES];
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [CNT_W-1:0]   cnt_dec;
  logic [FRAME_W-1:0] rd_frame_r;

  assign cnt_dec    = cnt_r - CNT_W'(1);
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CNT_W'(MAX_FREE_PAGES));
  assign pop_frame  = rd_frame_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (req.push) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (req.pop) begin
      cnt_nxt = cnt_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Write at the fill level, read the top entry one below it.
  always_ff @(posedge clk) begin
    if (req.push) begin
      frame_mem[cnt_r[IDX_W-1:0]] <= push_frame;
    end
    if (req.pop) begin
      rd_frame_r <= frame_mem[cnt_dec[IDX_W-1:0]];
    end
  end

endmodule

### hw/rtl/free_page_stack_allocator.sv
// Channel | Direction | Fields
// in_     | slave     | tdata: page_address[31:0]; tuser: func[0]
// out_    | master    | tdata: granted_address[31:0]; tuser: status[2:0]
// cfg_    | write     | index 0 heap_base, index 1 heap_limit
//
// A free, or an allocate on an empty list, has its result written into the
// output queue from the input transfer. A granted allocate reads the frame
// memory into a registered top entry and marks a pending pop, and no input
// is taken while that pop waits. Results go into a two-entry output queue,
// so an input is taken while one result waits; the queue stalls input only
// when both slots are held. Synchronous reset empties the list and the queue;
// the frame memory is left as it is and needs no clearing pass.
`include "free_page_stack_allocator_assert.svh"

module free_page_stack_allocator
  import fpsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [ADDR_W-1:0] in_tdata,   // [31:0] page_address
  input  logic              in_tuser,   // [0] func
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [ADDR_W-1:0] out_tdata,  // [31:0] granted_address
  output logic [STAT_W-1:0] out_tuser,  // [2:0] status
  // configuration
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [ADDR_W-1:0] cfg_wdata
);

  logic [ADDR_W-1:0]  heap_base_r;
  logic [ADDR_W-1:0]  heap_limit_r;

  logic               pop_pend_r;
  logic               pop_pend_nxt;

  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [ADDR_W-1:0]  out_addr_nxt;
  status_t            out_status_r;
  status_t            out_status_nxt;

  logic               skid_valid_r;
  logic               skid_valid_nxt;
  logic [ADDR_W-1:0]  skid_addr_r;
  logic [ADDR_W-1:0]  skid_addr_nxt;
  status_t            skid_status_r;
  status_t            skid_status_nxt;

  logic               in_xfer;
  logic               out_xfer;
  logic               is_free;
  stack_req_t         stk_req;
  stack_stat_t        stk_stat;
  logic [FRAME_W-1:0] pop_frame;

  status_t            chk_status;
  logic               res_push;
  logic [ADDR_W-1:0]  res_addr;
  status_t            res_status;

  // Hold input in reset, while a pop waits on the memory or both result
  // slots are full.
  assign in_tready = rst_n && !pop_pend_r && !skid_valid_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_valid_r && out_tready;
  assign is_free   = (in_tuser == FUNC_FREE);

  // Check order for a free: alignment, lower bound, upper bound, then room.
  always_comb begin
    priority if (!is_free) begin
      chk_status = stk_stat.empty ? ST_EMPTY : ST_OK;
    end else if (in_tdata[PAGE_SHIFT-1:0] != '0) begin
      chk_status = ST_UNALIGNED;
    end else if (in_tdata < heap_base_r) begin
      chk_status = ST_TOO_LOW;
    end else if (in_tdata > heap_limit_r) begin
      chk_status = ST_TOO_HIGH;
    end else if (stk_stat.full) begin
      chk_status = ST_FULL;
    end else begin
      chk_status = ST_OK;
    end
  end

  assign stk_req.push  = in_xfer && is_free && (chk_status == ST_OK);
  assign stk_req.pop   = in_xfer && !is_free && (chk_status == ST_OK);
  assign pop_pend_nxt  = stk_req.pop;

  // A granted allocate returns its result once the memory read lands;
  // everything else returns at once with a zero address.
  assign res_push   = pop_pend_r || (in_xfer && !stk_req.pop);
  assign res_addr   = pop_pend_r ? {pop_frame, {PAGE_SHIFT{1'b0}}} : '0;
  assign res_status = pop_pend_r ? ST_OK : chk_status;

  fpsa_frame_stack u_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (stk_req),
    .push_frame (in_tdata[ADDR_W-1:PAGE_SHIFT]),
    .stat       (stk_stat),
    .pop_frame  (pop_frame)
  );

  // Two-entry result queue: out register in front, skid slot behind it.
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_addr_nxt    = out_addr_r;
    out_status_nxt  = out_status_r;
    skid_valid_nxt  = skid_valid_r;
    skid_addr_nxt   = skid_addr_r;
    skid_status_nxt = skid_status_r;
    if (!out_valid_r || out_xfer) begin
      if (skid_valid_r) begin
        out_valid_nxt   = 1'b1;
        out_addr_nxt    = skid_addr_r;
        out_status_nxt  = skid_status_r;
        skid_valid_nxt  = res_push;
        skid_addr_nxt   = res_addr;
        skid_status_nxt = res_status;
      end else begin
        out_valid_nxt  = res_push;
        out_addr_nxt   = res_addr;
        out_status_nxt = res_status;
      end
    end else if (res_push) begin
      skid_valid_nxt  = 1'b1;
      skid_addr_nxt   = res_addr;
      skid_status_nxt = res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_pend_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      heap_base_r  <= '0;
      heap_limit_r <= '0;
    end else begin
      pop_pend_r   <= pop_pend_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HEAP_BASE:  heap_base_r  <= cfg_wdata;
          CFG_HEAP_LIMIT: heap_limit_r <= cfg_wdata;
          default:        heap_base_r  <= heap_base_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_addr_r    <= out_addr_nxt;
    out_status_r  <= out_status_nxt;
    skid_addr_r   <= skid_addr_nxt;
    skid_status_r <= skid_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_status_r;

  // A pending pop lasts exactly one cycle.
  `FPSA_ASSERT(a_pop_one_cycle, pop_pend_r |=> !pop_pend_r, "pop pending for two cycles")
  // The skid slot only fills behind a held out register.
  `FPSA_ASSERT(a_skid_behind_out, skid_valid_r |-> out_valid_r, "skid holds result, out empty")
  // A free always has its result queued on the next cycle.
  `FPSA_ASSERT(a_free_result, (in_xfer && is_free) |=> out_valid_r, "free result not queued")
  // A granted pop never shows up with an error status.
  `FPSA_ASSERT(a_pop_ok, pop_pend_r |-> (res_status == ST_OK), "pop result with error status")

endmodule

### verif/free_page_stack_allocator_test.sv
`timescale 1ns / 100ps

module free_page_stack_allocator_test;
  import fpsa_pkg::*;

  localparam logic [ADDR_W-1:0] OFFSET_MASK = ADDR_W'((1 << PAGE_SHIFT) - 1);
  localparam longint unsigned MAX_FRAME = (longint'(1) << FRAME_W) - 1;

  // One request on the input channel and the reply it earns.
  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] addr;
  } page_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } page_reply_t;

  // Patterns the result side cycles through when it backs up the block.
  typedef enum logic [1:0] {
    FLOW,    // always ready
    COIN,    // ready at random
    SPARSE,  // ready one cycle in four
    CHOKE    // long stall, then a short ready window
  } stall_mode_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [ADDR_W-1:0] in_tdata   = '0;  // [31:0] page_address
  logic              in_tuser   = 1'b0;  // [0] func
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [ADDR_W-1:0] out_tdata;  // [31:0] granted_address
  logic [STAT_W-1:0] out_tuser;  // [2:0] status
  logic              cfg_we     = 1'b0;
  logic              cfg_index  = CFG_HEAP_BASE;
  logic [ADDR_W-1:0] cfg_wdata  = '0;

  free_page_stack_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Our own copy of the free list and the heap bounds.
  logic [FRAME_W-1:0] frame_stack [MAX_FREE_PAGES];
  int unsigned        stack_depth = 0;
  logic [ADDR_W-1:0]  heap_lo = '0;
  logic [ADDR_W-1:0]  heap_hi = '0;

  page_req_t   request_queue[$];    // requests not yet offered to the block
  page_reply_t awaited_replies[$];  // replies owed for accepted requests
  page_req_t   next_req;
  bit          in_took = 1'b0;      // input transfer seen at the last rising edge
  int          mismatches = 0;

  // Sender burst state and receiver stall state.
  int          burst_left = 0;
  int          gap_left = 0;
  stall_mode_t rx_mode = FLOW;
  int          rx_mode_left = 0;
  int unsigned rx_tick = 0;

  // Apply one request to the local free list and return the reply it earns.
  // For a free, alignment is checked first, then the lower bound, then the upper
  // bound, and only then is room on the stack looked at.
  function automatic page_reply_t serve_request(page_req_t req);
    page_reply_t rep;
    rep.addr   = '0;
    rep.status = ST_OK;
    if (req.func == FUNC_ALLOC) begin
      if (stack_depth == 0) begin
        rep.status = ST_EMPTY;
      end else begin
        stack_depth--;
        rep.addr = {frame_stack[stack_depth], {PAGE_SHIFT{1'b0}}};
      end
    end else if ((req.addr & OFFSET_MASK) != '0) begin
      rep.status = ST_UNALIGNED;
    end else if (req.addr < heap_lo) begin
      rep.status = ST_TOO_LOW;
    end else if (req.addr > heap_hi) begin
      rep.status = ST_TOO_HIGH;
    end else if (stack_depth >= MAX_FREE_PAGES) begin
      // full stack: drop the page
      rep.status = ST_FULL;
    end else begin
      frame_stack[stack_depth] = req.addr[ADDR_W-1:PAGE_SHIFT];
      stack_depth++;
    end
    return rep;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic add_req(input logic func, input logic [ADDR_W-1:0] addr);
    page_req_t req;
    req.func = func;
    req.addr = addr;
    request_queue.push_back(req);
  endtask

  // Pick a page address to free under the current bounds: mostly one that
  // lands inside the heap window, the rest unaligned, below or above it.
  function automatic logic [ADDR_W-1:0] pick_free_addr();
    longint unsigned lo_f, hi_f, f;
    logic [ADDR_W-1:0] a;
    int unsigned roll;
    lo_f = heap_lo;
    lo_f = (lo_f + (1 << PAGE_SHIFT) - 1) >> PAGE_SHIFT;
    hi_f = heap_hi >> PAGE_SHIFT;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      a = $urandom();
      if ((a & OFFSET_MASK) == '0) a[$urandom_range(0, PAGE_SHIFT - 1)] = 1'b1;
      return a;
    end
    if (roll < 20 && lo_f > 0)
      f = $urandom_range(0, lo_f - 1);
    else if (roll < 28 && hi_f < MAX_FRAME)
      f = $urandom_range(hi_f + 1, MAX_FRAME);
    else if (lo_f <= hi_f)
      f = $urandom_range(lo_f, hi_f);
    else
      f = $urandom_range(0, MAX_FRAME);
    return ADDR_W'(f << PAGE_SHIFT);
  endfunction

  // Queue n requests in runs of the same kind, so that pushes and pops
  // chain deep into the stack; free_pct steers the fill level.
  task automatic queue_random(input int n, input int free_pct);
    int   sent;
    int   run;
    logic is_free;
    sent = 0;
    while (sent < n) begin
      is_free = ($urandom_range(0, 99) < free_pct);
      run = $urandom_range(1, 16);
      for (int k = 0; k < run && sent < n; k++) begin
        if (is_free) add_req(FUNC_FREE, pick_free_addr());
        else add_req(FUNC_ALLOC, $urandom());
        sent++;
      end
    end
  endtask

  // Hold until every request has been taken and every reply has come back,
  // then let the block settle.
  task automatic wait_idle();
    while (request_queue.size() != 0 || in_tvalid || awaited_replies.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both bounds while the block is idle.
  task automatic set_heap(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HEAP_BASE;
    cfg_wdata <= lo;
    @(negedge clk);
    cfg_index <= CFG_HEAP_LIMIT;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_we <= 1'b0;
    heap_lo = lo;
    heap_hi = hi;
    @(posedge clk);
  endtask

  // Random window: base anywhere, limit up to span_frames pages above it.
  task automatic set_random_window(input int unsigned span_frames);
    longint unsigned lo, hi;
    lo = longint'($urandom_range(0, MAX_FRAME)) << PAGE_SHIFT;
    if ($urandom_range(0, 1)) lo += $urandom_range(0, (1 << PAGE_SHIFT) - 1);
    hi = lo + (longint'($urandom_range(0, span_frames)) << PAGE_SHIFT)
       + $urandom_range(0, (1 << PAGE_SHIFT) - 1);
    if (hi > 64'h0000_0000_FFFF_FFFF) hi = 64'h0000_0000_FFFF_FFFF;
    set_heap(ADDR_W'(lo), ADDR_W'(hi));
  endtask

  // Driver: offer queued requests at the falling edge, in bursts with gaps.
  // Hold the current request until a transfer takes it.
  always @(negedge clk) begin : driver
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (request_queue.size() > 0) begin
        next_req = request_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_req.addr;
        in_tuser  <= next_req.func;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // end of burst: a gap now and then, sometimes none at all
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: switch between stall patterns, each held for a random stretch.
  always @(negedge clk) begin : receiver
    if (rx_mode_left == 0) begin
      rx_mode = stall_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 200);
    end
    rx_mode_left--;
    rx_tick++;
    case (rx_mode)
      FLOW:    out_tready <= 1'b1;
      COIN:    out_tready <= 1'($urandom_range(0, 1));
      SPARSE:  out_tready <= (rx_tick % 4 == 0);
      default: out_tready <= (rx_tick % 16 >= 10);
    endcase
  end

  // Monitor: predict on each input transfer, check each result transfer
  // against the oldest reply owed.
  always @(posedge clk) begin : monitor
    page_reply_t owed;
    in_took = rst_n && in_tvalid && in_tready;
    if (in_took)
      awaited_replies.push_back(serve_request('{func: in_tuser, addr: in_tdata}));
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_replies.size() == 0) begin
        flag_mismatch($sformatf("unexpected result addr=%h status=%0d",
                                out_tdata, out_tuser));
      end else begin
        owed = awaited_replies.pop_front();
        if (out_tdata !== owed.addr || out_tuser !== owed.status)
          flag_mismatch($sformatf("result addr=%h status=%0d, expected addr=%h status=%0d",
                                  out_tdata, out_tuser, owed.addr, owed.status));
      end
    end
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] a, b;

    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Reset bounds are both zero, so only the page at address zero fits.
    add_req(FUNC_ALLOC, 32'hFFFF_FFFF);  // empty list
    add_req(FUNC_FREE, 32'h0000_0000);
    add_req(FUNC_FREE, 32'h0000_0000);   // duplicate free is pushed again
    add_req(FUNC_FREE, 32'h0000_1000);   // above limit
    add_req(FUNC_FREE, 32'h0000_0001);   // unaligned
    add_req(FUNC_FREE, 32'hFFFF_FFFF);   // unaligned wins over the bounds
    add_req(FUNC_ALLOC, 32'h0000_0000);  // page zero comes back as ok
    add_req(FUNC_ALLOC, 32'h1234_5678);
    add_req(FUNC_ALLOC, 32'h0000_0000);  // empty again

    set_heap(32'h0001_0000, 32'hFFFF_F000);
    add_req(FUNC_FREE, 32'h0000_F000);   // below base
    add_req(FUNC_FREE, 32'h0001_0000);   // exactly at base
    add_req(FUNC_FREE, 32'hFFFF_F000);   // exactly at limit
    add_req(FUNC_FREE, 32'h8000_0800);   // unaligned
    add_req(FUNC_FREE, 32'hFFFF_F000);
    add_req(FUNC_ALLOC, 32'h0000_0000);
    add_req(FUNC_ALLOC, 32'h0000_0000);
    add_req(FUNC_ALLOC, 32'h0000_0000);
    add_req(FUNC_ALLOC, 32'h0000_0000);

    // Base above limit: every aligned free fails one bound or the other.
    set_heap(32'h8000_0000, 32'h7FFF_F000);
    add_req(FUNC_FREE, 32'h8000_0000);
    add_req(FUNC_FREE, 32'h7FFF_F000);
    add_req(FUNC_ALLOC, 32'h0000_0000);

    set_heap(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(FUNC_FREE, 32'hFFFF_F000);
    add_req(FUNC_FREE, 32'h0000_0000);

    // Random part, one bound setting per phase; each write drains first.
    set_heap(32'h0000_0000, 32'hFFFF_F000);
    queue_random(300, 50);

    set_random_window(2048);
    queue_random(300, 60);

    // Build the stack up, then drain it mostly with allocates.
    set_heap(32'h0000_0000, 32'hFFFF_F000);
    queue_random(250, 55);
    queue_random(150, 10);

    set_heap(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_random(150, 30);

    a = $urandom();
    b = $urandom();
    if (a == b) b = a ^ 32'h8000_0000;
    set_heap((a > b) ? a : b, (a > b) ? b : a);
    queue_random(150, 50);

    set_heap(32'h0000_0000, 32'h0000_0000);
    queue_random(200, 50);

    // Narrow window: a handful of pages freed over and over.
    set_random_window(3);
    queue_random(250, 50);

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
